>>> rtl/core/ialu_pkg.sv
package ialu_pkg;

  // Operand and result width.
  localparam int DATA_W = 32;

  // Largest factor taken; from this factor on the wrapped product is zero.
  localparam int FACT_CAP = 34;

  // Step counter width: it holds the division step and the factorial factor.
  localparam int CNT_W = 6;

  // Operation codes carried in the input tuser.
  localparam logic [2:0] MODE_ADD  = 3'd0;
  localparam logic [2:0] MODE_SUB  = 3'd1;
  localparam logic [2:0] MODE_MUL  = 3'd2;
  localparam logic [2:0] MODE_DIV  = 3'd3;
  localparam logic [2:0] MODE_REM  = 3'd4;
  localparam logic [2:0] MODE_FACT = 3'd5;
  localparam logic [2:0] MODE_POW  = 3'd6;

  // Request to the shared arithmetic unit.
  typedef struct packed {
    logic [DATA_W:0]   add_x;
    logic [DATA_W:0]   add_y;
    logic              add_sub;
    logic [DATA_W-1:0] mul_x;
    logic [DATA_W-1:0] mul_y;
  } ialu_req_t;

  // Response from the shared arithmetic unit.
  typedef struct packed {
    logic [DATA_W-1:0] sum;
    logic              carry;
    logic [DATA_W-1:0] prod;
  } ialu_rsp_t;

  // Sequencer status towards the stream interface.
  typedef struct packed {
    logic ready;
    logic done;
  } ialu_stat_t;

endpackage

>>> rtl/core/ialu_unit.sv
module ialu_unit (
  input  ialu_pkg::ialu_req_t req,
  output ialu_pkg::ialu_rsp_t rsp
);

  logic [ialu_pkg::DATA_W+1:0] total;
  logic [ialu_pkg::DATA_W:0]   y_in;

  // One adder that subtracts by inverting the second operand; the carry out
  // is high when the subtraction did not borrow.
  assign y_in  = req.add_sub ? ~req.add_y : req.add_y;
  assign total = {1'b0, req.add_x} + {1'b0, y_in}
               + {{(ialu_pkg::DATA_W+1){1'b0}}, req.add_sub};

  assign rsp.sum   = total[ialu_pkg::DATA_W-1:0];
  assign rsp.carry = total[ialu_pkg::DATA_W+1];

  // One multiplier; only the low word is kept, which wraps the product.
  assign rsp.prod = req.mul_x * req.mul_y;

endmodule

>>> rtl/core/ialu_seq.sv
module ialu_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [2:0]                    mode_in,
  input  logic [ialu_pkg::DATA_W-1:0]   a_in,
  input  logic [ialu_pkg::DATA_W-1:0]   b_in,
  input  logic                          take,
  output ialu_pkg::ialu_stat_t          stat,
  output logic [ialu_pkg::DATA_W-1:0]   result,
  output logic                          dz
);

  localparam int W = ialu_pkg::DATA_W;
  localparam int CW = ialu_pkg::CNT_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ALU  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_FIX  = 3'd3;
  localparam logic [2:0] ST_FACT = 3'd4;
  localparam logic [2:0] ST_PMUL = 3'd5;
  localparam logic [2:0] ST_PSQR = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [CW-1:0] DIV_LAST = CW'(W - 1);
  localparam logic [CW-1:0] FACT_MAX = CW'(ialu_pkg::FACT_CAP);
  localparam logic [W-1:0]  ONE      = W'(1);

  logic [2:0]    state, state_next;
  logic [2:0]    mode, mode_next;
  logic [W-1:0]  acc, acc_next;
  logic [W-1:0]  opa, opa_next;
  logic [W-1:0]  opb, opb_next;
  logic [W-1:0]  rem, rem_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] lim, lim_next;
  logic          flip, flip_next;
  logic          dz_reg, dz_next;

  logic [W-1:0]  mag_a, mag_b;
  logic          a_pos, b_pos;
  logic [W-1:0]  fix_src;

  ialu_pkg::ialu_req_t req;
  ialu_pkg::ialu_rsp_t rsp;

  ialu_unit u_unit (
    .req (req),
    .rsp (rsp)
  );

  // Operand magnitudes and sign tests used when an item is loaded.
  assign mag_a = a_in[W-1] ? (W'(0) - a_in) : a_in;
  assign mag_b = b_in[W-1] ? (W'(0) - b_in) : b_in;
  assign a_pos = !a_in[W-1] && (a_in != '0);
  assign b_pos = !b_in[W-1] && (b_in != '0);

  assign fix_src = (mode == ialu_pkg::MODE_DIV) ? opa : rem;

  // Sequencer: picks the unit's inputs and the next register values.
  always_comb begin
    state_next = state;
    mode_next  = mode;
    acc_next   = acc;
    opa_next   = opa;
    opb_next   = opb;
    rem_next   = rem;
    cnt_next   = cnt;
    lim_next   = lim;
    flip_next  = flip;
    dz_next    = dz_reg;

    req.add_x   = {1'b0, opa};
    req.add_y   = {1'b0, opb};
    req.add_sub = (mode == ialu_pkg::MODE_SUB);
    req.mul_x   = opa;
    req.mul_y   = opb;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          mode_next = mode_in;
          dz_next   = 1'b0;
          acc_next  = ONE;
          opa_next  = a_in;
          opb_next  = b_in;
          unique case (mode_in)
            ialu_pkg::MODE_ADD, ialu_pkg::MODE_SUB, ialu_pkg::MODE_MUL: begin
              state_next = ST_ALU;
            end
            ialu_pkg::MODE_DIV, ialu_pkg::MODE_REM: begin
              if (b_in == '0) begin
                acc_next   = '0;
                dz_next    = 1'b1;
                state_next = ST_DONE;
              end else begin
                opa_next   = mag_a;
                opb_next   = mag_b;
                rem_next   = '0;
                cnt_next   = '0;
                flip_next  = (mode_in == ialu_pkg::MODE_DIV) ?
                             (a_in[W-1] ^ b_in[W-1]) : a_in[W-1];
                state_next = ST_DIV;
              end
            end
            ialu_pkg::MODE_FACT: begin
              if (a_pos) begin
                lim_next   = (a_in > W'(ialu_pkg::FACT_CAP)) ? FACT_MAX : a_in[CW-1:0];
                cnt_next   = CNT_ONE;
                state_next = ST_FACT;
              end else begin
                state_next = ST_DONE;
              end
            end
            ialu_pkg::MODE_POW: begin
              state_next = b_pos ? ST_PMUL : ST_DONE;
            end
            default: begin
              acc_next   = '0;
              state_next = ST_DONE;
            end
          endcase
        end
      end

      // Add, subtract or multiply on the shared unit, into the accumulator.
      ST_ALU: begin
        acc_next   = (mode == ialu_pkg::MODE_MUL) ? rsp.prod : rsp.sum;
        state_next = ST_DONE;
      end

      // Restoring division, one quotient bit a cycle, dividend bits shifted
      // out of opa while quotient bits shift in.
      ST_DIV: begin
        req.add_x   = {rem, opa[W-1]};
        req.add_y   = {1'b0, opb};
        req.add_sub = 1'b1;
        rem_next    = rsp.carry ? rsp.sum : {rem[W-2:0], opa[W-1]};
        opa_next    = {opa[W-2:0], rsp.carry};
        cnt_next    = cnt + CNT_ONE;
        if (cnt == DIV_LAST) begin
          state_next = ST_FIX;
        end
      end

      // Sign correction of the quotient or remainder.
      ST_FIX: begin
        req.add_x   = '0;
        req.add_y   = {1'b0, fix_src};
        req.add_sub = 1'b1;
        acc_next    = flip ? rsp.sum : fix_src;
        state_next  = ST_DONE;
      end

      // Factorial: one factor multiplied in per cycle.
      ST_FACT: begin
        req.mul_x = acc;
        req.mul_y = W'(cnt);
        acc_next  = rsp.prod;
        if (cnt == lim) begin
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + CNT_ONE;
        end
      end

      // Power, multiply step: take the base in when the exponent bit is set.
      ST_PMUL: begin
        req.mul_x = acc;
        req.mul_y = opa;
        if (opb[0]) begin
          acc_next = rsp.prod;
        end
        state_next = ST_PSQR;
      end

      // Power, square step: square the base and drop the exponent bit.
      ST_PSQR: begin
        req.mul_x  = opa;
        req.mul_y  = opa;
        opa_next   = rsp.prod;
        opb_next   = {1'b0, opb[W-1:1]};
        state_next = (opb[W-1:1] == '0) ? ST_DONE : ST_PMUL;
      end

      ST_DONE: begin
        if (take) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    mode   <= mode_next;
    acc    <= acc_next;
    opa    <= opa_next;
    opb    <= opb_next;
    rem    <= rem_next;
    cnt    <= cnt_next;
    lim    <= lim_next;
    flip   <= flip_next;
    dz_reg <= dz_next;
  end

  assign stat.ready = (state == ST_IDLE);
  assign stat.done  = (state == ST_DONE);
  assign result     = acc;
  assign dz         = dz_reg;

endmodule

>>> rtl/core/integer_alu_with_factorial_power.sv
// Channel   Direction  Content
// s_axis    in         tdata: operand_a, operand_b; tuser: mode
// m_axis    out        tdata: result; tuser: divide_by_zero
//
// After accept: add, subtract and multiply pass the ALU state; divide and
// remainder take one quotient bit a cycle on the shared adder, then a sign
// fix; factorial one factor a cycle on the shared multiplier; power a
// multiply and a square step per exponent bit up to the top set bit.
// Input is ready only while the sequencer is idle, and a finished result waits
// there while the output register is full. Reset clears state and valid.
module integer_alu_with_factorial_power (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] operand_a, [63:32] operand_b
  input  logic [2:0]  s_axis_tuser,  // [2:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] result
  output logic        m_axis_tuser   // [0] divide_by_zero
);

  localparam int W = ialu_pkg::DATA_W;

  ialu_pkg::ialu_stat_t stat;
  logic [W-1:0]         seq_result;
  logic                 seq_dz;
  logic                 start;
  logic                 take;

  assign s_axis_tready = stat.ready;
  assign start         = s_axis_tvalid && stat.ready;

  // Hand the finished beat over when the output register is free or draining.
  assign take = stat.done && (!m_axis_tvalid || m_axis_tready);

  ialu_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .mode_in (s_axis_tuser),
    .a_in    (s_axis_tdata[W-1:0]),
    .b_in    (s_axis_tdata[2*W-1:W]),
    .take    (take),
    .stat    (stat),
    .result  (seq_result),
    .dz      (seq_dz)
  );

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (take) begin
      m_axis_tdata <= seq_result;
      m_axis_tuser <= seq_dz;
    end
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

// One result beat as the block should present it.
typedef struct packed {
  logic [31:0] result;
  logic        div_zero;
} alu_out_t;

// Holds the predicted results in order and compares each returned beat.
class alu_scoreboard;
  alu_out_t    expected_q[$];
  int unsigned mismatches;

  function new();
    mismatches = 0;
  endfunction

  // Works out the result of one operation, wrapped to 32 bits.
  function alu_out_t compute(logic [2:0] op, logic [31:0] a, logic [31:0] b);
    alu_out_t    res;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] acc;
    logic [31:0] base;
    logic [31:0] expo;
    int unsigned last_factor;
    res = '0;
    mag_a = a[31] ? (32'd0 - a) : a;
    mag_b = b[31] ? (32'd0 - b) : b;
    case (op)
      ialu_pkg::MODE_ADD: res.result = a + b;
      ialu_pkg::MODE_SUB: res.result = a - b;
      ialu_pkg::MODE_MUL: res.result = a * b;
      ialu_pkg::MODE_DIV: begin
        if (b == 32'd0) begin
          res.div_zero = 1'b1;
        end else begin
          acc = mag_a / mag_b;
          res.result = (a[31] != b[31]) ? (32'd0 - acc) : acc;
        end
      end
      ialu_pkg::MODE_REM: begin
        if (b == 32'd0) begin
          res.div_zero = 1'b1;
        end else begin
          acc = mag_a % mag_b;
          res.result = a[31] ? (32'd0 - acc) : acc;
        end
      end
      ialu_pkg::MODE_FACT: begin
        // Beyond 34 factors the product is a multiple of 2^32.
        acc = 32'd1;
        if (!a[31] && a != 32'd0) begin
          last_factor = (a > 32'd34) ? 34 : a;
          for (int unsigned i = 1; i <= last_factor; i++) acc = acc * i;
        end
        res.result = acc;
      end
      ialu_pkg::MODE_POW: begin
        // Square and multiply; a non-positive exponent gives one.
        acc = 32'd1;
        if (!b[31] && b != 32'd0) begin
          base = a;
          expo = b;
          while (expo != 32'd0) begin
            if (expo[0]) acc = acc * base;
            base = base * base;
            expo = expo >> 1;
          end
        end
        res.result = acc;
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  function void note_input(logic [2:0] op, logic [31:0] a, logic [31:0] b);
    expected_q.push_back(compute(op, a, b));
  endfunction

  function void check_result(logic [31:0] result, logic div_zero);
    alu_out_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: result beat with none expected: result %h flag %0b",
               $time, result, div_zero);
      mismatches++;
      return;
    end
    want = expected_q.pop_front();
    if (result !== want.result) begin
      $display("%0t: result mismatch: expected %h, actual %h",
               $time, want.result, result);
      mismatches++;
    end
    if (div_zero !== want.div_zero) begin
      $display("%0t: divide_by_zero mismatch: expected %0b, actual %0b",
               $time, want.div_zero, div_zero);
      mismatches++;
    end
  endfunction

  function int unsigned outstanding();
    return expected_q.size();
  endfunction
endclass

module tb;

  // Code the block does not define; it must give a zero result.
  localparam logic [2:0] MODE_NONE = 3'd7;
  localparam int unsigned RANDOM_OPS = 650;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 80;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;  // [31:0] operand_a, [63:32] operand_b
  logic [2:0]  s_axis_tuser;  // [2:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;  // [31:0] result
  logic        m_axis_tuser;  // [0] divide_by_zero

  alu_scoreboard sb;
  logic          steady_flow;
  int unsigned   cycle_count;

  integer_alu_with_factorial_power dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // Result side: random back-pressure, and a check of every accepted beat.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser);
    end
    m_axis_tready <= steady_flow || ($urandom_range(99) >= 27);
  end

  // Guard against a hung block.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Presents one operation and holds it until the block takes the beat.
  // Valid stays high between back-to-back operations.
  task automatic send_op(input logic [2:0] op, input logic [31:0] a, input logic [31:0] b);
    if (!steady_flow && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom};
      s_axis_tuser  <= 3'($urandom);
      do @(posedge clk); while ($urandom_range(99) < 27);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(op, a, b);
  endtask

  // Operand mix: full range, small values and the extremes.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return 32'($urandom_range(80)) - 32'd40;
      7:          return 32'h8000_0000;
      8:          return 32'h7FFF_FFFF;
      default:    return $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
    endcase
  endfunction

  task automatic send_random_op();
    logic [2:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    int unsigned pick;
    pick = $urandom_range(99);
    op = (pick < 96) ? 3'(pick % 7) : MODE_NONE;
    a = pick_operand();
    b = pick_operand();
    case (op)
      ialu_pkg::MODE_DIV, ialu_pkg::MODE_REM: if ($urandom_range(9) == 0) b = 32'd0;
      ialu_pkg::MODE_FACT: if ($urandom_range(9) < 7) a = $urandom_range(40);
      ialu_pkg::MODE_POW:  if ($urandom_range(1) == 0) b = $urandom_range(40);
      default: ;
    endcase
    send_op(op, a, b);
  endtask

  initial begin
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    steady_flow = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ialu_pkg::MODE_ADD;
    m_axis_tready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: field extremes and every corner of each operation.
    send_op(ialu_pkg::MODE_ADD,  32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_op(ialu_pkg::MODE_ADD,  32'h8000_0000, 32'h8000_0000);
    send_op(ialu_pkg::MODE_SUB,  32'h8000_0000, 32'd1);
    send_op(ialu_pkg::MODE_SUB,  32'd0, 32'h8000_0000);
    send_op(ialu_pkg::MODE_MUL,  32'hFFFF_FFFF, 32'h8000_0000);
    send_op(ialu_pkg::MODE_MUL,  32'h1234_5678, 32'h9ABC_DEF0);
    send_op(ialu_pkg::MODE_DIV,  32'd100, 32'd0);
    send_op(ialu_pkg::MODE_REM,  32'h8000_0000, 32'd0);
    send_op(ialu_pkg::MODE_DIV,  32'h8000_0000, 32'hFFFF_FFFF);
    send_op(ialu_pkg::MODE_REM,  32'h8000_0000, 32'hFFFF_FFFF);
    send_op(ialu_pkg::MODE_DIV,  -32'sd7, 32'd2);
    send_op(ialu_pkg::MODE_REM,  -32'sd7, 32'd2);
    send_op(ialu_pkg::MODE_REM,  32'd7, -32'sd2);
    send_op(ialu_pkg::MODE_DIV,  32'h7FFF_FFFF, 32'h8000_0000);
    send_op(ialu_pkg::MODE_FACT, 32'd0, 32'd0);
    send_op(ialu_pkg::MODE_FACT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(ialu_pkg::MODE_FACT, 32'd12, 32'd0);
    send_op(ialu_pkg::MODE_FACT, 32'd33, 32'd0);
    send_op(ialu_pkg::MODE_FACT, 32'd34, 32'd0);
    send_op(ialu_pkg::MODE_FACT, 32'h7FFF_FFFF, 32'd0);
    send_op(ialu_pkg::MODE_POW,  32'd3, 32'd0);
    send_op(ialu_pkg::MODE_POW,  32'd3, 32'h8000_0000);
    send_op(ialu_pkg::MODE_POW,  32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_op(ialu_pkg::MODE_POW,  32'd3, 32'd19);
    send_op(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Random part, with a stretch of uninterrupted flow in the middle.
    for (int unsigned n = 0; n < RANDOM_OPS; n++) begin
      steady_flow = (n >= 250 && n < 350);
      send_random_op();
    end
    steady_flow = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/core/ialu_pkg.sv
rtl/core/ialu_unit.sv
rtl/core/ialu_seq.sv
rtl/core/integer_alu_with_factorial_power.sv
sim/tb.sv
